/* rtl/scso_pkg.sv */
package scso_pkg;

  // glyph geometry, in glyph units
  localparam int unsigned GLYPH_UNITS_W = 4;
  localparam int unsigned GLYPH_UNITS_H = 7;
  localparam int unsigned SLOT_UNITS    = 5;
  localparam int unsigned SLOT_COUNT    = 8;
  localparam int unsigned DIGIT_BASE    = 10;
  localparam int unsigned SEG_COUNT     = 10;
  localparam int unsigned TENS_MAX      = 127 / DIGIT_BASE;

  // corner arithmetic: unwrapped corners stay below 2**CORNER_W
  localparam int unsigned CORNER_W    = 12;
  localparam int unsigned GEOM_W      = CORNER_W + 2;
  localparam int unsigned DIV_W       = 13;
  localparam int unsigned RECIP_SHIFT = 12;
  localparam int unsigned RECIP_W     = 8;

  // column span kinds: offset and width in units of the scale
  localparam int unsigned XK_WIDE  = 0;
  localparam int unsigned XK_LEFT  = 1;
  localparam int unsigned XK_RIGHT = 2;
  localparam int unsigned XK_HALF  = 3;
  localparam int unsigned XK_COLON = 4;
  localparam int unsigned X_KINDS  = 5;

  localparam int unsigned XK_OFF [X_KINDS] =
    '{0, 0, GLYPH_UNITS_W - 1, GLYPH_UNITS_W / 2, GLYPH_UNITS_W / 2};
  localparam int unsigned XK_SIZE [X_KINDS] =
    '{GLYPH_UNITS_W, 1, 1, GLYPH_UNITS_W / 2, 1};

  // row span kinds
  localparam int unsigned YK_BASE = 0;
  localparam int unsigned YK_FULL = 1;
  localparam int unsigned YK_LOW  = 2;
  localparam int unsigned YK_TOP  = 3;
  localparam int unsigned YK_MID  = 4;
  localparam int unsigned YK_UP   = 5;
  localparam int unsigned Y_KINDS = 6;

  // span kinds for each segment bit
  localparam int unsigned SEG_XK [SEG_COUNT] = '{
    XK_WIDE, XK_LEFT, XK_LEFT, XK_WIDE, XK_RIGHT,
    XK_RIGHT, XK_WIDE, XK_RIGHT, XK_LEFT, XK_HALF
  };
  localparam int unsigned SEG_YK [SEG_COUNT] = '{
    YK_BASE, YK_FULL, YK_LOW, YK_TOP, YK_FULL,
    YK_LOW, YK_MID, YK_UP, YK_UP, YK_TOP
  };

  localparam int unsigned CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_GLYPH_SCALE,
    REG_INK_COLOR
  } cfg_reg_e;

  localparam logic [3:0]  SCALE_RESET = 4'd2;
  localparam logic [31:0] INK_RESET   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [31:0] background_color;
    logic [6:0]  hours_value;
    logic [6:0]  minutes_value;
    logic [6:0]  seconds_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic        covered;
  } out_item_t;

  function automatic logic [SEG_COUNT-1:0] seg_mask(input logic [3:0] digit);
    logic [SEG_COUNT-1:0] m;
    case (digit)
      4'd0:    m = 10'h01B;
      4'd1:    m = 10'h210;
      4'd2:    m = 10'h0CD;
      4'd3:    m = 10'h0E9;
      4'd4:    m = 10'h150;
      4'd5:    m = 10'h169;
      4'd6:    m = 10'h06B;
      4'd7:    m = 10'h018;
      4'd8:    m = 10'h05B;
      4'd9:    m = 10'h158;
      default: m = '0;
    endcase
    return m;
  endfunction

  // {tens mod 10, units} of a 7-bit value
  function automatic logic [7:0] digit_split(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = '0;
    for (int t = 1; t <= TENS_MAX; t++) begin
      if (v >= 7'(t * DIGIT_BASE)) tens = 4'(t);
    end
    units = v - 7'(tens) * 7'(DIGIT_BASE);
    if (tens >= 4'(DIGIT_BASE)) tens = tens - 4'(DIGIT_BASE);
    return {tens, units[3:0]};
  endfunction

endpackage

/* rtl/segment_clock_overlay.sv */
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
// cfg     | input     | cfg_we_i, cfg_addr_i      | cfg_wdata_i
//
// One item per cycle sustained unless out_stall_i holds the output; an accepted item waits
// in the input register, and its result is registered in the result register behind it.
// The cycle is set by the pixel test against the registered glyph bounds.
// A config write lands in the config registers; glyph bounds rebuilt from them are registered.
// rst_ni (async, active low) empties both registers and restores the config defaults.
// out_stall_i holds the result register; in_stall_o rises only when both registers are full.
module segment_clock_overlay import scso_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [31:0]           cfg_wdata_i
);

  localparam int unsigned XW = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT + 1);

  logic [9:0]  origin_x_q;
  logic [8:0]  origin_y_q;
  logic [3:0]  scale_q;
  logic [31:0] ink_q;

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  out_item_t result;
  logic      s2_ready, in_ready, s1_fire, in_fire;

  logic [XW-1:0] xlo [SLOT_COUNT][X_KINDS];
  logic [XW-1:0] xhi [SLOT_COUNT][X_KINDS];
  logic [YW-1:0] ylo [Y_KINDS];
  logic [YW-1:0] yhi [Y_KINDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      scale_q    <= SCALE_RESET;
      ink_q      <= INK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ORIGIN_X:    origin_x_q <= cfg_wdata_i[9:0];
        REG_ORIGIN_Y:    origin_y_q <= cfg_wdata_i[8:0];
        REG_GLYPH_SCALE: scale_q    <= cfg_wdata_i[3:0];
        REG_INK_COLOR:   ink_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  scso_geom #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_geom (
    .clk_i         (clk_i),
    .origin_x_i    (origin_x_q),
    .origin_y_i    (origin_y_q),
    .glyph_scale_i (scale_q),
    .xlo_o         (xlo),
    .xhi_o         (xhi),
    .ylo_o         (ylo),
    .yhi_o         (yhi)
  );

  scso_cover #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_cover (
    .item_i      (s1_q),
    .ink_color_i (ink_q),
    .xlo_i       (xlo),
    .xhi_i       (xhi),
    .ylo_i       (ylo),
    .yhi_i       (yhi),
    .result_o    (result)
  );

  assign s2_ready = !out_valid_q || !out_stall_i;
  assign s1_fire  = s1_valid_q && s2_ready;
  assign in_ready = !s1_valid_q || s2_ready;
  assign in_fire  = in_valid_i && in_ready;

  assign s1_valid_d  = in_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_q <= in_data_i;
    if (s1_fire) out_q <= result;
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o)
    else $error("item leaving the input register did not reach the output");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_q))
    else $error("blocked item in the input register was lost or changed");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("result appeared without an item in the input register");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !s1_valid_q |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule

/* rtl/scso_geom.sv */
module scso_geom import scso_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480,
  localparam int unsigned XW = $clog2(SCREEN_WIDTH),
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT + 1)
) (
  input  logic          clk_i,
  input  logic [9:0]    origin_x_i,
  input  logic [8:0]    origin_y_i,
  input  logic [3:0]    glyph_scale_i,
  output logic [XW-1:0] xlo_o [SLOT_COUNT][X_KINDS],
  output logic [XW-1:0] xhi_o [SLOT_COUNT][X_KINDS],
  output logic [YW-1:0] ylo_o [Y_KINDS],
  output logic [YW-1:0] yhi_o [Y_KINDS]
);

  localparam logic [DIV_W-1:0]   W_DIV   = DIV_W'(SCREEN_WIDTH);
  localparam logic [DIV_W-1:0]   H_DIV   = DIV_W'(SCREEN_HEIGHT);
  localparam logic [RECIP_W-1:0] W_RECIP = RECIP_W'((1 << RECIP_SHIFT) / SCREEN_WIDTH);
  localparam logic [RECIP_W-1:0] H_RECIP = RECIP_W'((1 << RECIP_SHIFT) / SCREEN_HEIGHT);

  // v mod div by reciprocal multiply; the estimate is low by at most one
  function automatic logic [CORNER_W-1:0] wrap(input logic [CORNER_W-1:0] v,
                                               input logic [DIV_W-1:0] div,
                                               input logic [RECIP_W-1:0] recip);
    logic [CORNER_W+RECIP_W-1:0] prod;
    logic [RECIP_W-1:0]          q;
    logic [DIV_W+RECIP_W-1:0]    qd;
    logic [CORNER_W:0]           r;
    prod = (CORNER_W+RECIP_W)'(v) * (CORNER_W+RECIP_W)'(recip);
    q    = prod[RECIP_SHIFT +: RECIP_W];
    qd   = (DIV_W+RECIP_W)'(q) * (DIV_W+RECIP_W)'(div);
    r    = (CORNER_W+1)'(v) - qd[CORNER_W:0];
    if (r >= div) r = r - div;
    return r[CORNER_W-1:0];
  endfunction

  logic [CORNER_W-1:0] s_c, h_c, h2_c, hms_c;
  logic [CORNER_W-1:0] y_off  [Y_KINDS];
  logic [CORNER_W-1:0] y_size [Y_KINDS];

  logic [XW-1:0] xlo_d [SLOT_COUNT][X_KINDS];
  logic [XW-1:0] xhi_d [SLOT_COUNT][X_KINDS];
  logic [YW-1:0] ylo_d [Y_KINDS];
  logic [YW-1:0] yhi_d [Y_KINDS];
  logic [XW-1:0] xlo_q [SLOT_COUNT][X_KINDS];
  logic [XW-1:0] xhi_q [SLOT_COUNT][X_KINDS];
  logic [YW-1:0] ylo_q [Y_KINDS];
  logic [YW-1:0] yhi_q [Y_KINDS];

  assign s_c   = CORNER_W'(glyph_scale_i);
  assign h_c   = CORNER_W'(GLYPH_UNITS_H) * s_c;
  assign h2_c  = h_c >> 1;
  assign hms_c = CORNER_W'(GLYPH_UNITS_H - 1) * s_c;

  assign y_off[YK_BASE]  = '0;
  assign y_off[YK_FULL]  = '0;
  assign y_off[YK_LOW]   = '0;
  assign y_off[YK_TOP]   = hms_c;
  assign y_off[YK_MID]   = h2_c;
  assign y_off[YK_UP]    = h2_c;
  assign y_size[YK_BASE] = s_c;
  assign y_size[YK_FULL] = h_c;
  assign y_size[YK_LOW]  = h2_c;
  assign y_size[YK_TOP]  = s_c;
  assign y_size[YK_MID]  = s_c;
  assign y_size[YK_UP]   = h2_c;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    for (genvar j = 0; j < X_KINDS; j++) begin : g_xk
      localparam int unsigned OFF = SLOT_UNITS * i + XK_OFF[j];
      logic [CORNER_W-1:0]      corner, size, wrapped;
      logic signed [GEOM_W-1:0] lim, pos;

      assign corner  = CORNER_W'(origin_x_i) + CORNER_W'(OFF) * s_c;
      assign size    = CORNER_W'(XK_SIZE[j]) * s_c;
      assign wrapped = wrap(corner, W_DIV, W_RECIP);
      assign lim     = GEOM_W'(SCREEN_WIDTH) - GEOM_W'(size) - GEOM_W'(1);
      assign pos     = (lim < 0) ? '0 :
                       ($signed({2'b00, wrapped}) > lim) ? lim : $signed({2'b00, wrapped});
      assign xlo_d[i][j] = XW'(pos);
      // glyph spans are narrower than the screen, so the end never needs a cut
      assign xhi_d[i][j] = XW'(pos + $signed(GEOM_W'(size)));
    end
  end

  for (genvar j = 0; j < Y_KINDS; j++) begin : g_yk
    logic [CORNER_W-1:0]      corner, wrapped;
    logic signed [GEOM_W-1:0] lim, pos, fin;

    assign corner  = CORNER_W'(origin_y_i) + y_off[j];
    assign wrapped = wrap(corner, H_DIV, H_RECIP);
    assign lim     = GEOM_W'(SCREEN_HEIGHT) - GEOM_W'(y_size[j]) - GEOM_W'(1);
    assign pos     = (lim < 0) ? '0 :
                     ($signed({2'b00, wrapped}) > lim) ? lim : $signed({2'b00, wrapped});
    assign fin     = pos + $signed(GEOM_W'(y_size[j]));
    assign ylo_d[j] = YW'(pos);
    assign yhi_d[j] = (fin > $signed(GEOM_W'(SCREEN_HEIGHT))) ? YW'(SCREEN_HEIGHT) : YW'(fin);
  end

  // bounds are registered and follow the config registers in the next cycle
  always_ff @(posedge clk_i) begin
    xlo_q <= xlo_d;
    xhi_q <= xhi_d;
    ylo_q <= ylo_d;
    yhi_q <= yhi_d;
  end

  assign xlo_o = xlo_q;
  assign xhi_o = xhi_q;
  assign ylo_o = ylo_q;
  assign yhi_o = yhi_q;

endmodule

/* rtl/scso_cover.sv */
module scso_cover import scso_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480,
  localparam int unsigned XW = $clog2(SCREEN_WIDTH),
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT + 1)
) (
  input  in_item_t      item_i,
  input  logic [31:0]   ink_color_i,
  input  logic [XW-1:0] xlo_i [SLOT_COUNT][X_KINDS],
  input  logic [XW-1:0] xhi_i [SLOT_COUNT][X_KINDS],
  input  logic [YW-1:0] ylo_i [Y_KINDS],
  input  logic [YW-1:0] yhi_i [Y_KINDS],
  output out_item_t     result_o
);

  localparam int unsigned PXW = (XW > 10) ? XW : 10;
  localparam int unsigned PYW = (YW > 9) ? YW : 9;

  logic [PXW-1:0]        px;
  logic [PYW-1:0]        py;
  logic [X_KINDS-1:0]    in_x [SLOT_COUNT];
  logic [Y_KINDS-1:0]    in_y;
  logic [7:0]            pair [3];
  logic [SLOT_COUNT-1:0] slot_hit;
  logic                  hit;

  assign px = PXW'(item_i.pixel_x);
  assign py = PYW'(item_i.pixel_y);

  assign pair[0] = digit_split(item_i.hours_value);
  assign pair[1] = digit_split(item_i.minutes_value);
  assign pair[2] = digit_split(item_i.seconds_value);

  for (genvar j = 0; j < Y_KINDS; j++) begin : g_y
    assign in_y[j] = (py >= PYW'(ylo_i[j])) && (py < PYW'(yhi_i[j]));
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    for (genvar j = 0; j < X_KINDS; j++) begin : g_x
      assign in_x[i][j] = (px >= PXW'(xlo_i[i][j])) && (px < PXW'(xhi_i[i][j]));
    end

    if (i % 3 == 2) begin : g_colon
      assign slot_hit[i] = in_x[i][XK_COLON] & (in_y[YK_BASE] | in_y[YK_TOP]);
    end else begin : g_digit
      logic [3:0]           dig;
      logic [SEG_COUNT-1:0] cov;
      if (i % 3 == 0) begin : g_tens
        assign dig = pair[i / 3][7:4];
      end else begin : g_units
        assign dig = pair[i / 3][3:0];
      end
      for (genvar k = 0; k < SEG_COUNT; k++) begin : g_seg
        assign cov[k] = in_x[i][SEG_XK[k]] & in_y[SEG_YK[k]];
      end
      assign slot_hit[i] = |(cov & seg_mask(dig));
    end
  end

  assign hit                  = |slot_hit;
  assign result_o.covered     = hit;
  assign result_o.pixel_color = hit ? ink_color_i : item_i.background_color;

endmodule
